[rtl/core/q2e_pkg.sv]
// Shared types, constants and the arctangent table of the quaternion to Euler angle block.
// Depends on nothing; every other file of the block imports it.
package q2e_pkg;

    localparam int QUAT_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Products of two parts are kept in units of 2^-30.
    localparam int PROD_W = 32;
    // CORDIC datapath width; it holds the doubled sums with the CORDIC gain on top.
    localparam int CW     = 37;
    // Width of the pitch cosine root and of the small pitch sine.
    localparam int SQ_W   = 31;
    // Width of the radicand 2^60 - s*s.
    localparam int RAD_W  = 61;
    localparam int ACC_W  = 32;
    localparam int ANG_W  = 16;
    localparam int NPROD  = 9;
    localparam int FIFO_DEPTH = 4;

    localparam logic signed [CW-1:0] ONE_Q30      = CW'(64'd1 << 30);
    localparam logic [RAD_W-1:0]     RAD_ONE      = RAD_W'(64'd1 << 60);
    localparam logic [ACC_W-1:0]     QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 16'sd16384;

    typedef struct packed {
        logic signed [CW-1:0]   sr;
        logic signed [CW-1:0]   cr;
        logic signed [CW-1:0]   sy;
        logic signed [CW-1:0]   cy;
        logic signed [SQ_W-1:0] sp;
        logic [RAD_W-1:0]       rad;
        logic                   clamp;
        logic                   pneg;
    } q2e_item_t;

    // atan(2^-i) with 2^31 standing for pi.
    function automatic logic [ACC_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ACC_W-1:0] r;
        case (idx)
            5'd0:  r = 32'h2000_0000;
            5'd1:  r = 32'h12E4_051E;
            5'd2:  r = 32'h09FB_385B;
            5'd3:  r = 32'h0511_11D4;
            5'd4:  r = 32'h028B_0D43;
            5'd5:  r = 32'h0145_D7E1;
            5'd6:  r = 32'h00A2_F61E;
            5'd7:  r = 32'h0051_7C55;
            5'd8:  r = 32'h0028_BE53;
            5'd9:  r = 32'h0014_5F2F;
            5'd10: r = 32'h000A_2F98;
            5'd11: r = 32'h0005_17CC;
            5'd12: r = 32'h0002_8BE6;
            5'd13: r = 32'h0001_45F3;
            5'd14: r = 32'h0000_A2FA;
            5'd15: r = 32'h0000_517D;
            5'd16: r = 32'h0000_28BE;
            5'd17: r = 32'h0000_145F;
            5'd18: r = 32'h0000_0A30;
            5'd19: r = 32'h0000_0518;
            5'd20: r = 32'h0000_028C;
            5'd21: r = 32'h0000_0146;
            5'd22: r = 32'h0000_00A3;
            5'd23: r = 32'h0000_0051;
            5'd24: r = 32'h0000_0029;
            5'd25: r = 32'h0000_0014;
            5'd26: r = 32'h0000_000A;
            5'd27: r = 32'h0000_0005;
            5'd28: r = 32'h0000_0003;
            5'd29: r = 32'h0000_0001;
            5'd30: r = 32'h0000_0001;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/q2e_if.sv]
// Valid/ready channel interfaces for quaternion beats and Euler angle beats.
// Depends on q2e_pkg.
interface quat_if import q2e_pkg::*; #(parameter int QUAT_WIDTH = QUAT_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface euler_if import q2e_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] yaw_angle;
    logic                    pitch_clamped;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

[rtl/core/quaternion_to_euler_angles.sv]
// Top level of the quaternion to Z-Y-X Euler angle converter.
// Depends on q2e_pkg, quat_if, euler_if, q2e_front, q2e_fifo and q2e_back.
//
//   Channel    Direction  Beat
//   quat_in    in         quat_w, quat_x, quat_y, quat_z (signed Q1.(QUAT_WIDTH-1))
//   euler_out  out        roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One beat is taken per cycle and one result leaves per cycle when the sink keeps up.
// A beat passes four front stages, the queue, the square-root stages, one per root bit,
// and the CORDIC lanes, each one stage per micro-rotation, then the output register.
// Reset clears only the valid bits, the queue pointers and the queue count.
// A stalled output holds the back end; the queue then lets the front keep taking
// beats until it fills.
module quaternion_to_euler_angles import q2e_pkg::*; #(
    parameter int QUAT_WIDTH   = QUAT_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    quat_if.sink    quat_in,
    euler_if.source euler_out
);

    logic      push, can_push, take, avail;
    q2e_item_t wr_item, rd_item;

    q2e_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .quat_in (quat_in),
        .push_ok (can_push),
        .push    (push),
        .item    (wr_item)
    );

    q2e_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (wr_item),
        .can_push (can_push),
        .take     (take),
        .avail    (avail),
        .rd_item  (rd_item)
    );

    q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .rd_item   (rd_item),
        .take      (take),
        .euler_out (euler_out)
    );

endmodule

[rtl/core/q2e_front.sv]
// Front end: takes quaternion beats, forms the products and sums, classifies pitch
// saturation and prepares the radicand. Depends on q2e_pkg and quat_if.
module q2e_front import q2e_pkg::*; #(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    quat_if.sink      quat_in,
    input  logic      push_ok,
    output logic      push,
    output q2e_item_t item
);

    localparam int W  = QUAT_WIDTH;
    localparam int PW = 2 * W;

    localparam int P_WX = 0;
    localparam int P_YZ = 1;
    localparam int P_XX = 2;
    localparam int P_YY = 3;
    localparam int P_WY = 4;
    localparam int P_ZX = 5;
    localparam int P_WZ = 6;
    localparam int P_XY = 7;
    localparam int P_ZZ = 8;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [W-1:0] opa [NPROD];
    logic signed [W-1:0] opb [NPROD];
    logic signed [PROD_W-1:0] prod_next [NPROD];
    logic signed [PROD_W-1:0] prod_reg  [NPROD];

    logic signed [CW-1:0] sr_next, cr_next, sy_next, cy_next, sp_full;
    logic                 clamp_next;
    logic signed [CW-1:0] sr_reg, cr_reg, sy_reg, cy_reg;
    logic signed [SQ_W-1:0] sp_reg;
    logic                 clamp_reg, pneg_reg;

    logic signed [2*SQ_W-1:0] sq;
    q2e_item_t item_next, item_reg;

    // The whole front stalls only when its last stage holds a beat the queue cannot take.
    assign en            = !v4_reg || push_ok;
    assign push          = v4_reg && push_ok;
    assign quat_in.ready = en;
    assign item          = item_reg;

    assign opa[P_WX] = qw_reg;  assign opb[P_WX] = qx_reg;
    assign opa[P_YZ] = qy_reg;  assign opb[P_YZ] = qz_reg;
    assign opa[P_XX] = qx_reg;  assign opb[P_XX] = qx_reg;
    assign opa[P_YY] = qy_reg;  assign opb[P_YY] = qy_reg;
    assign opa[P_WY] = qw_reg;  assign opb[P_WY] = qy_reg;
    assign opa[P_ZX] = qz_reg;  assign opb[P_ZX] = qx_reg;
    assign opa[P_WZ] = qw_reg;  assign opb[P_WZ] = qz_reg;
    assign opa[P_XY] = qx_reg;  assign opb[P_XY] = qy_reg;
    assign opa[P_ZZ] = qz_reg;  assign opb[P_ZZ] = qz_reg;

    // Each product is brought to units of 2^-30 with a floor shift.
    for (genvar p = 0; p < NPROD; p++) begin : g_prod
        logic signed [PW-1:0] full;
        assign full = opa[p] * opb[p];
        if (PW >= PROD_W) begin : g_down
            assign prod_next[p] = PROD_W'(full >>> (PW - PROD_W));
        end
        else begin : g_up
            assign prod_next[p] = PROD_W'(full) <<< (PROD_W - PW);
        end
    end

    always_comb
    begin
        sr_next    = (CW'(prod_reg[P_WX]) + CW'(prod_reg[P_YZ])) <<< 1;
        cr_next    = ONE_Q30 - ((CW'(prod_reg[P_XX]) + CW'(prod_reg[P_YY])) <<< 1);
        sp_full    = (CW'(prod_reg[P_WY]) - CW'(prod_reg[P_ZX])) <<< 1;
        sy_next    = (CW'(prod_reg[P_WZ]) + CW'(prod_reg[P_XY])) <<< 1;
        cy_next    = ONE_Q30 - ((CW'(prod_reg[P_YY]) + CW'(prod_reg[P_ZZ])) <<< 1);
        clamp_next = (sp_full >= ONE_Q30) || (sp_full <= -ONE_Q30);
    end

    assign sq = sp_reg * sp_reg;

    always_comb
    begin
        item_next.sr    = sr_reg;
        item_next.cr    = cr_reg;
        item_next.sy    = sy_reg;
        item_next.cy    = cy_reg;
        item_next.sp    = sp_reg;
        item_next.rad   = RAD_ONE - RAD_W'(sq);
        item_next.clamp = clamp_reg;
        item_next.pneg  = pneg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= quat_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qw_reg <= quat_in.quat_w;
            qx_reg <= quat_in.quat_x;
            qy_reg <= quat_in.quat_y;
            qz_reg <= quat_in.quat_z;
            for (int p = 0; p < NPROD; p++)
            begin
                prod_reg[p] <= prod_next[p];
            end
            sr_reg    <= sr_next;
            cr_reg    <= cr_next;
            sy_reg    <= sy_next;
            cy_reg    <= cy_next;
            // A saturated sine is replaced by zero, since its root is never used.
            sp_reg    <= clamp_next ? '0 : sp_full[SQ_W-1:0];
            clamp_reg <= clamp_next;
            pneg_reg  <= sp_full[CW-1];
            item_reg  <= item_next;
        end
    end

endmodule

[rtl/core/q2e_fifo.sv]
// Short queue between the front end and the arithmetic back end.
// Depends on q2e_pkg.
module q2e_fifo import q2e_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q2e_item_t wr_item,
    output logic      can_push,
    input  logic      take,
    output logic      avail,
    output q2e_item_t rd_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q2e_item_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign avail    = (count_reg != '0);
    assign pop      = avail && take;
    // A full queue still takes a beat in the cycle that it hands one on.
    assign can_push = (count_reg != CNT_W'(DEPTH)) || pop;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[rtl/core/q2e_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) as a 16-bit binary angle.
// Depends on q2e_pkg.
module q2e_cordic import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [CW-1:0]    y_in,
    input  logic signed [CW-1:0]    x_in,
    output logic signed [ANG_W-1:0] angle
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic [ACC_W-1:0]     acc_reg [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];

    logic signed [CW-1:0] x_next [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_next [0:CORDIC_STEPS];
    logic [ACC_W-1:0]     acc_next [0:CORDIC_STEPS];

    // Negative x is first turned by a quarter turn into the right half plane.
    always_comb
    begin
        x_next[0]   = x_in;
        y_next[0]   = y_in;
        acc_next[0] = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next[0]   = y_in;
                y_next[0]   = -x_in;
                acc_next[0] = QUARTER_TURN;
            end
            else
            begin
                x_next[0]   = -y_in;
                y_next[0]   = x_in;
                acc_next[0] = -QUARTER_TURN;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic up;
        assign up = !y_reg[k][CW-1];
        assign x_next[k+1]   = up ? x_reg[k] + (y_reg[k] >>> k) : x_reg[k] - (y_reg[k] >>> k);
        assign y_next[k+1]   = up ? y_reg[k] - (x_reg[k] >>> k) : y_reg[k] + (x_reg[k] >>> k);
        assign acc_next[k+1] = up ? acc_reg[k] + atan_entry(5'(k))
                                  : acc_reg[k] - atan_entry(5'(k));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                acc_reg[k] <= acc_next[k];
            end
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    // Round half up onto 16 bits; the top of the range wraps.
    assign angle = zero_reg[CORDIC_STEPS] ? '0
                 : ANG_W'(acc_reg[CORDIC_STEPS][ACC_W-1:ACC_W-ANG_W]
                          + ANG_W'(acc_reg[CORDIC_STEPS][ACC_W-ANG_W-1]));

endmodule

[rtl/core/q2e_back.sv]
// Back end: bit-per-stage square root for the pitch cosine, three CORDIC lanes
// and the output register. Depends on q2e_pkg, euler_if and q2e_cordic.
module q2e_back import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      avail,
    input  q2e_item_t rd_item,
    output logic      take,
    euler_if.source   euler_out
);

    logic en, load;

    logic             sv_reg  [0:SQ_W];
    logic [RAD_W-1:0] rem_reg [0:SQ_W];
    logic [SQ_W-1:0]  root_reg [0:SQ_W];
    q2e_item_t        itm_reg [0:SQ_W];
    logic [RAD_W-1:0] rem_next [SQ_W];
    logic [SQ_W-1:0]  root_next [SQ_W];

    logic cv_reg     [0:CORDIC_STEPS];
    logic cclamp_reg [0:CORDIC_STEPS];
    logic cpneg_reg  [0:CORDIC_STEPS];

    logic signed [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
    logic                    out_valid_reg;
    logic signed [ANG_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                    clamp_reg;
    q2e_item_t               sq_item;

    // One enable for the whole back end: it moves whenever the output slot frees.
    assign en   = !out_valid_reg || euler_out.ready;
    assign take = en;
    assign load = avail && en;

    // Root bit I is tried against the remainder v - root^2.
    for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
        localparam int I = SQ_W - 1 - k;
        logic [63:0] trial;
        logic        fit;
        assign trial = (64'(root_reg[k]) << (I + 1)) + (64'd1 << (2 * I));
        assign fit   = 64'(rem_reg[k]) >= trial;
        assign rem_next[k]  = fit ? RAD_W'(64'(rem_reg[k]) - trial) : rem_reg[k];
        assign root_next[k] = fit ? (root_reg[k] | (SQ_W'(1) << I)) : root_reg[k];
    end

    assign sq_item = itm_reg[SQ_W];

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (sq_item.sr),
        .x_in  (sq_item.cr),
        .angle (roll_ang)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (CW'(sq_item.sp)),
        .x_in  (signed'(CW'(root_reg[SQ_W]))),
        .angle (pitch_ang)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (sq_item.sy),
        .x_in  (sq_item.cy),
        .angle (yaw_ang)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_W; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= load;
            for (int k = 0; k < SQ_W; k++)
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
            cv_reg[0] <= sv_reg[SQ_W];
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                cv_reg[k+1] <= cv_reg[k];
            end
            out_valid_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            itm_reg[0]  <= rd_item;
            rem_reg[0]  <= rd_item.rad;
            root_reg[0] <= '0;
            for (int k = 0; k < SQ_W; k++)
            begin
                itm_reg[k+1]  <= itm_reg[k];
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
            end
            cclamp_reg[0] <= sq_item.clamp;
            cpneg_reg[0]  <= sq_item.pneg;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                cclamp_reg[k+1] <= cclamp_reg[k];
                cpneg_reg[k+1]  <= cpneg_reg[k];
            end
            roll_reg  <= roll_ang;
            yaw_reg   <= yaw_ang;
            clamp_reg <= cclamp_reg[CORDIC_STEPS];
            if (cclamp_reg[CORDIC_STEPS])
            begin
                pitch_reg <= cpneg_reg[CORDIC_STEPS] ? -PITCH_LIMIT : PITCH_LIMIT;
            end
            else
            begin
                pitch_reg <= pitch_ang;
            end
        end
    end

    assign euler_out.valid         = out_valid_reg;
    assign euler_out.roll_angle    = roll_reg;
    assign euler_out.pitch_angle   = pitch_reg;
    assign euler_out.yaw_angle     = yaw_reg;
    assign euler_out.pitch_clamped = clamp_reg;

endmodule

[rtl/core/q2e_checker.sv]
// Port-level checks of the quaternion to Euler angle converter, bound to the top level.
// Depends on q2e_pkg.
module q2e_checker import q2e_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [ANG_W-1:0] roll_angle,
    input logic signed [ANG_W-1:0] pitch_angle,
    input logic signed [ANG_W-1:0] yaw_angle,
    input logic                    pitch_clamped
);

    logic [7:0] pending_reg;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_angle)
            && $stable(pitch_angle) && $stable(yaw_angle) && $stable(pitch_clamped))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result with no quaternion outstanding");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pitch_clamped |-> pitch_angle == PITCH_LIMIT
            || pitch_angle == -PITCH_LIMIT)
        else $error("clamped pitch is not a quarter turn");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_angle <= PITCH_LIMIT && pitch_angle >= -PITCH_LIMIT)
        else $error("pitch beyond a quarter turn");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (quat_in.valid),
    .in_ready      (quat_in.ready),
    .out_valid     (euler_out.valid),
    .out_ready     (euler_out.ready),
    .roll_angle    (euler_out.roll_angle),
    .pitch_angle   (euler_out.pitch_angle),
    .yaw_angle     (euler_out.yaw_angle),
    .pitch_clamped (euler_out.pitch_clamped)
);

[tb/tb_top.sv]
// Self-checking testbench of the quaternion to Z-Y-X Euler angle converter.
// Depends on q2e_pkg, quat_if, euler_if and quaternion_to_euler_angles.
`timescale 1ns / 1ps
module tb_top;
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamp;
    } angles_t;

    localparam int LATENCY  = CORDIC_STEPS_DEF + 39;
    localparam int WD_LIMIT = 20000;

    logic clk;
    logic rst_n;

    quat_if  quat_in();
    euler_if euler_out();

    quaternion_to_euler_angles dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat_in   (quat_in.sink),
        .euler_out (euler_out.source)
    );

    quat_t   pending_quats[$];
    angles_t expected_angles[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    logic    hold_off;
    logic    stall_go = 1'b0;
    int      error_count;
    int      quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Floor shift of a signed 64-bit value.
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint prod_q30(longint a, longint b);
        return fshr(a * b, 32);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        logic [31:0] sum;
        longint      t;
        longint      dx;
        longint      dy;
        acc = 32'd0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; acc = QUARTER_TURN;
            end
            else
            begin
                x = -y; y = t; acc = 32'd0 - QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; acc = acc + atan_entry(5'(i));
            end
            else
            begin
                x = x - dx; y = y + dy; acc = acc - atan_entry(5'(i));
            end
        end
        sum = acc + 32'h8000;
        return sum[31:16];
    endfunction

    function automatic angles_t euler_of(quat_t q);
        angles_t a;
        longint  w, x, y, z, sr, cr, sp, sy, cy;
        longint unsigned s2;
        w = longint'(q.w) <<< 16;
        x = longint'(q.x) <<< 16;
        y = longint'(q.y) <<< 16;
        z = longint'(q.z) <<< 16;
        sr = 2 * (prod_q30(w, x) + prod_q30(y, z));
        cr = (64'sd1 <<< 30) - 2 * (prod_q30(x, x) + prod_q30(y, y));
        sp = 2 * (prod_q30(w, y) - prod_q30(z, x));
        sy = 2 * (prod_q30(w, z) + prod_q30(x, y));
        cy = (64'sd1 <<< 30) - 2 * (prod_q30(y, y) + prod_q30(z, z));
        if (sp >= (64'sd1 <<< 30))
        begin
            a.pitch = PITCH_LIMIT; a.clamp = 1'b1;
        end
        else if (sp <= -(64'sd1 <<< 30))
        begin
            a.pitch = -PITCH_LIMIT; a.clamp = 1'b1;
        end
        else
        begin
            s2 = sp * sp;
            a.pitch = vector_angle(sp, longint'(root64((64'd1 << 60) - s2)));
            a.clamp = 1'b0;
        end
        a.roll = vector_angle(sr, cr);
        a.yaw  = vector_angle(sy, cy);
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic logic signed [15:0] any16();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random unit-ish quaternion: mostly near unit norm so pitch stays in range.
    function automatic quat_t unit_quat();
        quat_t q;
        real   a, b, c, d, n;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        d = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        q.w = 16'($rtoi(a / n * 32767.0));
        q.x = 16'($rtoi(b / n * 32767.0));
        q.y = 16'($rtoi(c / n * 32767.0));
        q.z = 16'($rtoi(d / n * 32767.0));
        return q;
    endfunction

    function automatic quat_t mk(int w, int x, int y, int z);
        quat_t q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    // Driver: a beat stays on the bus until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_in.valid  <= 1'b0;
            quat_in.quat_w <= '0;
            quat_in.quat_x <= '0;
            quat_in.quat_y <= '0;
            quat_in.quat_z <= '0;
        end
        else if (!quat_in.valid || quat_in.ready)
        begin
            if (quat_in.valid)
                expected_angles.push_back(euler_of({quat_in.quat_w, quat_in.quat_x,
                                                    quat_in.quat_y, quat_in.quat_z}));
            if (pending_quats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                quat_t q;
                q = pending_quats.pop_front();
                quat_in.valid  <= 1'b1;
                quat_in.quat_w <= q.w;
                quat_in.quat_x <= q.x;
                quat_in.quat_y <= q.y;
                quat_in.quat_z <= q.z;
            end
            else
                quat_in.valid <= 1'b0;
        end
    end

    // Monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            euler_out.ready <= 1'b0;
            quiet_cycles    <= 0;
        end
        else
        begin
            if (euler_out.valid && euler_out.ready)
            begin
                angles_t e;
                if (expected_angles.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else
                begin
                    e = expected_angles.pop_front();
                    if (euler_out.roll_angle !== e.roll)
                        report_mismatch("roll_angle", euler_out.roll_angle, e.roll);
                    if (euler_out.pitch_angle !== e.pitch)
                        report_mismatch("pitch_angle", euler_out.pitch_angle, e.pitch);
                    if (euler_out.yaw_angle !== e.yaw)
                        report_mismatch("yaw_angle", euler_out.yaw_angle, e.yaw);
                    if (euler_out.pitch_clamped !== e.clamp)
                        report_mismatch("pitch_clamped", euler_out.pitch_clamped, e.clamp);
                end
            end
            if ((quat_in.valid && quat_in.ready) || (euler_out.valid && euler_out.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (hold_off)
                euler_out.ready <= 1'b0;
            else
                euler_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver stall, counted here, while the sender keeps offering beats.
    initial
    begin
        hold_off = 1'b0;
        wait (stall_go);
        repeat (50) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_quats.size() > 0 || quat_in.valid || expected_angles.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        error_count   = 0;
        send_idle_pct = 20;
        recv_idle_pct = 88;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identity, gimbal lock both ways, extremes, zero operands.
        pending_quats.push_back(mk(32767, 0, 0, 0));
        pending_quats.push_back(mk(0, 0, 0, 0));
        pending_quats.push_back(mk(23170, 0, 23170, 0));
        pending_quats.push_back(mk(23170, 0, -23170, 0));
        pending_quats.push_back(mk(23170, 23170, 23170, -23170));
        pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
        pending_quats.push_back(mk(32767, 32767, 32767, 32767));
        pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
        pending_quats.push_back(mk(0, 32767, 0, 0));
        pending_quats.push_back(mk(0, -32768, 0, 0));
        pending_quats.push_back(mk(0, 0, 0, 32767));
        pending_quats.push_back(mk(0, 0, 0, -32768));
        pending_quats.push_back(mk(0, 0, 32767, 0));
        pending_quats.push_back(mk(0, 23170, 0, 23170));
        pending_quats.push_back(mk(23170, 23170, 0, 0));
        pending_quats.push_back(mk(23170, -23170, 0, 0));
        pending_quats.push_back(mk(1, 0, 0, 0));
        pending_quats.push_back(mk(-1, -1, -1, -1));
        pending_quats.push_back(mk(16384, 16384, 16384, 16384));

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < 600; i++)
                pending_quats.push_back($urandom_range(0, 3) == 0 ?
                    mk(any16(), any16(), any16(), any16()) : unit_quat());
            // The sender runs flat out here, so the stall fills the block.
            if (phase == 2)
                stall_go = 1'b1;
            wait_drained();
            repeat (LATENCY) @(posedge clk);
            if (phase == 0)
            begin
                send_idle_pct = 88; recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
